// File: design/pab_pkg.sv
package pab_pkg;

    // Default sizing
    localparam int POINTS_DEF     = 4096;
    localparam int MAX_DEGREE_DEF = 16;
    localparam int MAX_EDGES_DEF  = 65536;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int EDGE_W   = 16;
    localparam int PIDX_W   = 12;
    localparam int QSLOT_W  = 4;
    localparam int STATUS_W = 2;
    localparam int ODEG_W   = 5;
    localparam int ENTRY_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_IGNORED  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE       = 2'd0,
        REG_FIRST_EDGE = 2'd1,
        REG_LAST_EDGE  = 2'd2
    } reg_idx_t;

    localparam logic [CFG_W-1:0] LAST_EDGE_RST = 16'hFFFF;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_RD1,
        S_RD2,
        S_RD3,
        S_RESP
    } state_t;

    // Port enables into the store
    typedef struct packed {
        logic deg_rd;
        logic deg_wr;
        logic lst_rd;
        logic lst_wr;
    } pab_mem_ctrl_t;

endpackage

// File: design/point_adjacency_builder_unit.sv
// An add goes through RD1, RD2 and RD3, a query through RD1 and RD2, an ignored edge or
// unused code to RESP; a clear zeroes one degree entry per cycle, then replies.
// Only one word is in progress at a time; an add's two degree look-ups per edge share
// the single read port of the degree memory.
// Reset (aresetn low, synchronous): control and config registers restored, then a sweep
// zeroes the degree memory; no word is accepted until it ends.
module point_adjacency_builder_unit #(
    parameter int POINTS     = pab_pkg::POINTS_DEF,
    parameter int MAX_DEGREE = pab_pkg::MAX_DEGREE_DEF,
    parameter int MAX_EDGES  = pab_pkg::MAX_EDGES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_we,
    input  logic [pab_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pab_pkg::CFG_W-1:0]      cfg_wdata,
    // input words
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [pab_pkg::OP_W-1:0]       s_operation,
    input  logic [pab_pkg::EDGE_W-1:0]     s_edge_id,
    input  logic                           s_end_a_present,
    input  logic [pab_pkg::PIDX_W-1:0]     s_end_a,
    input  logic                           s_end_b_present,
    input  logic [pab_pkg::PIDX_W-1:0]     s_end_b,
    input  logic [pab_pkg::PIDX_W-1:0]     s_query_point,
    input  logic [pab_pkg::QSLOT_W-1:0]    s_query_slot,
    // result words
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pab_pkg::STATUS_W-1:0]   m_status,
    output logic [pab_pkg::ODEG_W-1:0]     m_point_degree,
    output logic                           m_entry_valid,
    output logic [pab_pkg::ENTRY_W-1:0]    m_entry
);

    localparam int PW = $clog2(POINTS);
    localparam int SW = $clog2(MAX_DEGREE);
    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam logic [DW-1:0] DEG_MAX = DW'(MAX_DEGREE);
    localparam logic [PW-1:0] CNT_LAST = PW'(POINTS - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                      mode_reg;
    logic [pab_pkg::CFG_W-1:0] first_edge_reg;
    logic [pab_pkg::CFG_W-1:0] last_edge_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= 1'b0;
            first_edge_reg <= '0;
            last_edge_reg  <= pab_pkg::LAST_EDGE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pab_pkg::REG_MODE:       mode_reg       <= cfg_wdata[0];
                pab_pkg::REG_FIRST_EDGE: first_edge_reg <= cfg_wdata;
                pab_pkg::REG_LAST_EDGE:  last_edge_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Decode of the incoming word (used only in IDLE)
    // ------------------------------------------------------------------
    logic                        eid_ok;
    logic                        has_a, has_b, do_a_in, do_b_in;
    logic [pab_pkg::ENTRY_W-1:0] val_a_in, val_b_in;

    always_comb begin
        eid_ok = (s_edge_id >= first_edge_reg) && (s_edge_id <= last_edge_reg)
                 && (32'(s_edge_id) < 32'(MAX_EDGES));
        // an index beyond the memory counts as absent
        has_a  = s_end_a_present && (32'(s_end_a) < 32'(POINTS));
        has_b  = s_end_b_present && (32'(s_end_b) < 32'(POINTS));
        // mode 1 only records internal edges, each end gets the other point
        do_a_in  = mode_reg ? (has_a && has_b) : has_a;
        do_b_in  = mode_reg ? (has_a && has_b) : has_b;
        val_a_in = mode_reg ? pab_pkg::ENTRY_W'(s_end_b) : s_edge_id;
        val_b_in = mode_reg ? pab_pkg::ENTRY_W'(s_end_a) : s_edge_id;
    end

    // ------------------------------------------------------------------
    // Per-word working registers
    // ------------------------------------------------------------------
    logic                        is_query_reg;
    logic                        do_a_reg, do_b_reg;
    logic [PW-1:0]               pa_reg, pb_reg;
    logic [pab_pkg::ENTRY_W-1:0] val_a_reg, val_b_reg;
    logic                        qp_ok_reg;
    logic [PW-1:0]               qp_reg;
    logic [pab_pkg::QSLOT_W-1:0] qs_reg;
    pab_pkg::status_t            res_status_reg, res_status_next;
    // result of the first endpoint, kept for forwarding to the second
    logic                        a_wr_reg, ov_a_reg;
    logic [DW-1:0]               a_new_reg;

    pab_pkg::state_t state_reg, state_next;
    logic [PW-1:0]   cnt_reg, cnt_next;
    logic            clr_resp_reg, clr_resp_next;

    // store interface
    pab_pkg::pab_mem_ctrl_t      mem_ctrl;
    logic [PW-1:0]               deg_rd_addr, deg_wr_addr;
    logic [DW-1:0]               deg_wr_data, deg_rd_data;
    logic [PW+SW-1:0]            lst_rd_addr, lst_wr_addr;
    logic [pab_pkg::ENTRY_W-1:0] lst_wr_data, lst_rd_data;

    // output register
    logic                         m_valid_reg;
    logic [pab_pkg::STATUS_W-1:0] m_status_reg;
    logic [pab_pkg::ODEG_W-1:0]   m_point_degree_reg;
    logic                         m_entry_valid_reg;
    logic [pab_pkg::ENTRY_W-1:0]  m_entry_reg;

    logic                         out_free, out_load;
    pab_pkg::status_t             out_status;
    logic [pab_pkg::ODEG_W-1:0]   out_degree;
    logic                         out_entry_valid;
    logic [pab_pkg::ENTRY_W-1:0]  out_entry;

    logic capture, stage_a;

    // working degree values
    logic [DW-1:0] q_deg;
    logic          q_hit;
    logic [DW-1:0] deg_b;
    logic          a_fits, b_fits;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        clr_resp_next   = clr_resp_reg;
        res_status_next = res_status_reg;
        s_ready         = 1'b0;
        capture         = 1'b0;
        stage_a         = 1'b0;
        mem_ctrl        = '0;
        deg_rd_addr     = pa_reg;
        deg_wr_addr     = pa_reg;
        deg_wr_data     = '0;
        lst_rd_addr     = {qp_reg, SW'(qs_reg)};
        lst_wr_addr     = '0;
        lst_wr_data     = val_a_reg;
        out_load        = 1'b0;
        out_status      = pab_pkg::ST_OK;
        out_degree      = '0;
        out_entry_valid = 1'b0;
        out_entry       = '0;

        // query read-out
        q_deg  = qp_ok_reg ? deg_rd_data : '0;
        q_hit  = 32'(qs_reg) < 32'(q_deg);
        a_fits = deg_rd_data < DEG_MAX;
        // forward the first endpoint's new degree on a self-loop
        deg_b  = (a_wr_reg && (pb_reg == pa_reg)) ? a_new_reg : deg_rd_data;
        b_fits = deg_b < DEG_MAX;

        unique case (state_reg)
            pab_pkg::S_CLR: begin
                mem_ctrl.deg_wr = 1'b1;
                deg_wr_addr     = cnt_reg;
                deg_wr_data     = '0;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    cnt_next        = '0;
                    res_status_next = pab_pkg::ST_OK;
                    state_next      = clr_resp_reg ? pab_pkg::S_RESP : pab_pkg::S_IDLE;
                end
            end

            pab_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    capture         = 1'b1;
                    res_status_next = pab_pkg::ST_OK;
                    unique case (s_operation)
                        pab_pkg::OP_ADD: begin
                            if (!eid_ok || (!do_a_in && !do_b_in)) begin
                                res_status_next = pab_pkg::ST_IGNORED;
                                state_next      = pab_pkg::S_RESP;
                            end else begin
                                state_next = pab_pkg::S_RD1;
                            end
                        end
                        pab_pkg::OP_QUERY: state_next = pab_pkg::S_RD1;
                        pab_pkg::OP_CLEAR: begin
                            cnt_next      = '0;
                            clr_resp_next = 1'b1;
                            state_next    = pab_pkg::S_CLR;
                        end
                        default: state_next = pab_pkg::S_RESP;
                    endcase
                end
            end

            pab_pkg::S_RD1: begin
                mem_ctrl.deg_rd = 1'b1;
                deg_rd_addr     = is_query_reg ? qp_reg : pa_reg;
                mem_ctrl.lst_rd = is_query_reg;
                state_next      = pab_pkg::S_RD2;
            end

            pab_pkg::S_RD2: begin
                if (is_query_reg) begin
                    if (out_free) begin
                        out_load        = 1'b1;
                        out_degree      = pab_pkg::ODEG_W'(q_deg);
                        out_entry_valid = q_hit;
                        out_entry       = q_hit ? lst_rd_data : '0;
                        state_next      = pab_pkg::S_IDLE;
                    end
                end else begin
                    stage_a         = 1'b1;
                    mem_ctrl.deg_wr = do_a_reg && a_fits;
                    deg_wr_addr     = pa_reg;
                    deg_wr_data     = deg_rd_data + 1'b1;
                    mem_ctrl.lst_wr = do_a_reg && a_fits;
                    lst_wr_addr     = {pa_reg, deg_rd_data[SW-1:0]};
                    lst_wr_data     = val_a_reg;
                    mem_ctrl.deg_rd = 1'b1;
                    deg_rd_addr     = pb_reg;
                    state_next      = pab_pkg::S_RD3;
                end
            end

            pab_pkg::S_RD3: begin
                if (out_free) begin
                    mem_ctrl.deg_wr = do_b_reg && b_fits;
                    deg_wr_addr     = pb_reg;
                    deg_wr_data     = deg_b + 1'b1;
                    mem_ctrl.lst_wr = do_b_reg && b_fits;
                    lst_wr_addr     = {pb_reg, deg_b[SW-1:0]};
                    lst_wr_data     = val_b_reg;
                    out_load        = 1'b1;
                    out_status      = (ov_a_reg || (do_b_reg && !b_fits))
                                      ? pab_pkg::ST_OVERFLOW : pab_pkg::ST_OK;
                    state_next      = pab_pkg::S_IDLE;
                end
            end

            pab_pkg::S_RESP: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_status    = res_status_reg;
                    clr_resp_next = 1'b0;
                    state_next    = pab_pkg::S_IDLE;
                end
            end

            default: state_next = pab_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pab_pkg::S_CLR;
            cnt_reg      <= '0;
            clr_resp_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            clr_resp_reg <= clr_resp_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        if (capture) begin
            is_query_reg <= (s_operation == pab_pkg::OP_QUERY);
            do_a_reg     <= do_a_in;
            do_b_reg     <= do_b_in;
            pa_reg       <= PW'(s_end_a);
            pb_reg       <= PW'(s_end_b);
            val_a_reg    <= val_a_in;
            val_b_reg    <= val_b_in;
            qp_ok_reg    <= 32'(s_query_point) < 32'(POINTS);
            qp_reg       <= PW'(s_query_point);
            qs_reg       <= s_query_slot;
        end
        if (stage_a) begin
            a_wr_reg  <= do_a_reg && a_fits;
            ov_a_reg  <= do_a_reg && !a_fits;
            a_new_reg <= deg_rd_data + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Output register: frees the input side while a word waits
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg       <= out_status;
            m_point_degree_reg <= out_degree;
            m_entry_valid_reg  <= out_entry_valid;
            m_entry_reg        <= out_entry;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_point_degree = m_point_degree_reg;
    assign m_entry_valid  = m_entry_valid_reg;
    assign m_entry        = m_entry_reg;

    // ------------------------------------------------------------------
    // Degree and list memories
    // ------------------------------------------------------------------
    pab_store #(
        .POINTS     (POINTS),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_store (
        .aclk        (aclk),
        .ctrl        (mem_ctrl),
        .deg_rd_addr (deg_rd_addr),
        .deg_wr_addr (deg_wr_addr),
        .deg_wr_data (deg_wr_data),
        .deg_rd_data (deg_rd_data),
        .lst_rd_addr (lst_rd_addr),
        .lst_wr_addr (lst_wr_addr),
        .lst_wr_data (lst_wr_data),
        .lst_rd_data (lst_rd_data)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pab_pkg::S_CLR) |-> !s_ready)
        else $error("word accepted during degree sweep");

    a_sweep_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> (state_reg == pab_pkg::S_CLR))
        else $error("degree sweep not started after reset");

    a_degree_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_ctrl.deg_wr |-> (deg_wr_data <= DEG_MAX))
        else $error("degree written beyond list capacity");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result word overwritten before it was taken");

    a_one_word_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("word accepted while the previous one is in progress");

endmodule

// File: design/pab_store.sv
module pab_store #(
    parameter int POINTS     = pab_pkg::POINTS_DEF,
    parameter int MAX_DEGREE = pab_pkg::MAX_DEGREE_DEF
) (
    input  logic                      aclk,
    input  pab_pkg::pab_mem_ctrl_t    ctrl,
    input  logic [$clog2(POINTS)-1:0] deg_rd_addr,
    input  logic [$clog2(POINTS)-1:0] deg_wr_addr,
    input  logic [$clog2(MAX_DEGREE+1)-1:0] deg_wr_data,
    output logic [$clog2(MAX_DEGREE+1)-1:0] deg_rd_data,
    input  logic [$clog2(POINTS)+$clog2(MAX_DEGREE)-1:0] lst_rd_addr,
    input  logic [$clog2(POINTS)+$clog2(MAX_DEGREE)-1:0] lst_wr_addr,
    input  logic [pab_pkg::ENTRY_W-1:0] lst_wr_data,
    output logic [pab_pkg::ENTRY_W-1:0] lst_rd_data
);

    localparam int SW = $clog2(MAX_DEGREE);
    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int LIST_DEPTH = POINTS * (2 ** SW);

    logic [DW-1:0]               deg_mem [POINTS];
    logic [pab_pkg::ENTRY_W-1:0] lst_mem [LIST_DEPTH];

    logic [DW-1:0]               deg_q_reg;
    logic [pab_pkg::ENTRY_W-1:0] lst_q_reg;

    // degree per point
    always_ff @(posedge aclk) begin
        if (ctrl.deg_wr) begin
            deg_mem[deg_wr_addr] <= deg_wr_data;
        end
        if (ctrl.deg_rd) begin
            deg_q_reg <= deg_mem[deg_rd_addr];
        end
    end

    // list slots, addressed {point, slot}
    always_ff @(posedge aclk) begin
        if (ctrl.lst_wr) begin
            lst_mem[lst_wr_addr] <= lst_wr_data;
        end
        if (ctrl.lst_rd) begin
            lst_q_reg <= lst_mem[lst_rd_addr];
        end
    end

    assign deg_rd_data = deg_q_reg;
    assign lst_rd_data = lst_q_reg;

endmodule

// File: dv/testbench.sv
module testbench;

    // Operation code the block must treat as a no-op with an all-zero reply
    localparam logic [pab_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // Values of the mode register
    localparam bit MODE_EDGE_IDS   = 1'b0;
    localparam bit MODE_NEIGHBOURS = 1'b1;

    // Cycles without any handshake before the run is abandoned. A clear sweeps
    // POINTS entries and the post-reset sweep is as long, so this sits well above.
    localparam int STALL_LIMIT = 20000;

    // Receiver back-pressure: after this many replies, hold m_ready low for a while
    localparam int HOLD_AFTER  = 400;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [pab_pkg::OP_W-1:0]    operation;
        logic [pab_pkg::EDGE_W-1:0]  edge_id;
        logic                        a_present;
        logic [pab_pkg::PIDX_W-1:0]  end_a;
        logic                        b_present;
        logic [pab_pkg::PIDX_W-1:0]  end_b;
        logic [pab_pkg::PIDX_W-1:0]  query_point;
        logic [pab_pkg::QSLOT_W-1:0] query_slot;
    } edge_word_t;

    typedef struct packed {
        logic [pab_pkg::STATUS_W-1:0] status;
        logic [pab_pkg::ODEG_W-1:0]   degree;
        logic                         entry_valid;
        logic [pab_pkg::ENTRY_W-1:0]  entry;
    } reply_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                          cfg_we    = 1'b0;
    logic [pab_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [pab_pkg::CFG_W-1:0]     cfg_wdata = '0;

    logic                          s_valid         = 1'b0;
    logic                          s_ready;
    logic [pab_pkg::OP_W-1:0]      s_operation     = '0;
    logic [pab_pkg::EDGE_W-1:0]    s_edge_id       = '0;
    logic                          s_end_a_present = 1'b0;
    logic [pab_pkg::PIDX_W-1:0]    s_end_a         = '0;
    logic                          s_end_b_present = 1'b0;
    logic [pab_pkg::PIDX_W-1:0]    s_end_b         = '0;
    logic [pab_pkg::PIDX_W-1:0]    s_query_point   = '0;
    logic [pab_pkg::QSLOT_W-1:0]   s_query_slot    = '0;

    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [pab_pkg::STATUS_W-1:0]  m_status;
    logic [pab_pkg::ODEG_W-1:0]    m_point_degree;
    logic                          m_entry_valid;
    logic [pab_pkg::ENTRY_W-1:0]   m_entry;

    point_adjacency_builder_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_edge_id       (s_edge_id),
        .s_end_a_present (s_end_a_present),
        .s_end_a         (s_end_a),
        .s_end_b_present (s_end_b_present),
        .s_end_b         (s_end_b),
        .s_query_point   (s_query_point),
        .s_query_slot    (s_query_slot),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_point_degree  (m_point_degree),
        .m_entry_valid   (m_entry_valid),
        .m_entry         (m_entry)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow of the block: register copies, per-point degree and lists
    // ------------------------------------------------------------------
    bit                          mode_cfg       = MODE_EDGE_IDS;
    logic [pab_pkg::CFG_W-1:0]   first_edge_cfg = '0;
    logic [pab_pkg::CFG_W-1:0]   last_edge_cfg  = pab_pkg::LAST_EDGE_RST;

    int unsigned                 point_deg  [pab_pkg::POINTS_DEF];
    logic [pab_pkg::ENTRY_W-1:0] point_list [pab_pkg::POINTS_DEF*pab_pkg::MAX_DEGREE_DEF];

    edge_word_t word_backlog [$];   // words still to be offered
    reply_t     owed_results [$];   // replies predicted, not yet seen

    bit steady_run = 1'b0;          // set for a phase with no idling on either side

    int mismatches   = 0;
    int words_taken  = 0;
    int results_seen = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int adds_seen = 0, overflows_seen = 0, ignored_seen = 0;
    int queries_seen = 0, hits_seen = 0, clears_seen = 0;

    // Append to a point's list; a full list keeps its degree and reports overflow
    function automatic bit push_entry(int unsigned p, logic [pab_pkg::ENTRY_W-1:0] value);
        if (point_deg[p] >= pab_pkg::MAX_DEGREE_DEF) begin
            point_deg[p] = pab_pkg::MAX_DEGREE_DEF;
            return 1'b1;
        end
        point_list[p*pab_pkg::MAX_DEGREE_DEF + point_deg[p]] = value;
        point_deg[p]++;
        return 1'b0;
    endfunction

    // Apply one accepted word to the shadow state and return the reply it causes
    function automatic reply_t build_adjacency(edge_word_t w);
        reply_t r;
        bit     has_a;
        bit     has_b;
        bit     over;
        r = '0;
        case (w.operation)
            pab_pkg::OP_ADD: begin
                if (w.edge_id < first_edge_cfg || w.edge_id > last_edge_cfg ||
                    int'(w.edge_id) >= pab_pkg::MAX_EDGES_DEF) begin
                    r.status = pab_pkg::ST_IGNORED;
                end else begin
                    has_a = w.a_present && (int'(w.end_a) < pab_pkg::POINTS_DEF);
                    has_b = w.b_present && (int'(w.end_b) < pab_pkg::POINTS_DEF);
                    over  = 1'b0;
                    if (mode_cfg == MODE_EDGE_IDS) begin
                        if (!has_a && !has_b) begin
                            r.status = pab_pkg::ST_IGNORED;
                        end else begin
                            if (has_a) over |= push_entry(32'(w.end_a), w.edge_id);
                            if (has_b) over |= push_entry(32'(w.end_b), w.edge_id);
                            r.status = over ? pab_pkg::ST_OVERFLOW : pab_pkg::ST_OK;
                        end
                    end else if (!(has_a && has_b)) begin
                        r.status = pab_pkg::ST_IGNORED;
                    end else begin
                        // neighbour mode: each end records the other, self-loop twice
                        over  = push_entry(32'(w.end_a), pab_pkg::ENTRY_W'(w.end_b));
                        over |= push_entry(32'(w.end_b), pab_pkg::ENTRY_W'(w.end_a));
                        r.status = over ? pab_pkg::ST_OVERFLOW : pab_pkg::ST_OK;
                    end
                end
            end
            pab_pkg::OP_QUERY: begin
                if (int'(w.query_point) < pab_pkg::POINTS_DEF) begin
                    r.degree = pab_pkg::ODEG_W'(point_deg[w.query_point]);
                    if (w.query_slot < point_deg[w.query_point]) begin
                        r.entry_valid = 1'b1;
                        r.entry = point_list[w.query_point*pab_pkg::MAX_DEGREE_DEF
                                             + w.query_slot];
                    end
                end
            end
            pab_pkg::OP_CLEAR: begin
                foreach (point_deg[i]) point_deg[i] = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Word generation
    // ------------------------------------------------------------------

    // Mostly a small pool of points so lists fill up and overflow;
    // now and then any index so every bit of the field moves
    function automatic logic [pab_pkg::PIDX_W-1:0] pick_point();
        if ($urandom_range(99) < 85) return pab_pkg::PIDX_W'($urandom_range(15));
        return pab_pkg::PIDX_W'($urandom);
    endfunction

    // Edge ids aimed at the accepted range and just outside its bounds
    function automatic logic [pab_pkg::EDGE_W-1:0] pick_edge_id();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 65 && first_edge_cfg <= last_edge_cfg)
            return pab_pkg::EDGE_W'($urandom_range(last_edge_cfg, first_edge_cfg));
        if (r < 72) return first_edge_cfg;
        if (r < 79) return last_edge_cfg;
        if (r < 84) return first_edge_cfg - 1'b1;
        if (r < 89) return last_edge_cfg + 1'b1;
        return pab_pkg::EDGE_W'($urandom);
    endfunction

    function automatic edge_word_t random_word();
        edge_word_t  w;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 2)       w.operation = pab_pkg::OP_CLEAR;
        else if (r < 4)  w.operation = OP_UNUSED;
        else if (r < 35) w.operation = pab_pkg::OP_QUERY;
        else             w.operation = pab_pkg::OP_ADD;
        w.edge_id     = pick_edge_id();
        w.a_present   = ($urandom_range(99) < 90);
        w.end_a       = pick_point();
        w.b_present   = ($urandom_range(99) < 90);
        w.end_b       = ($urandom_range(99) < 8) ? w.end_a : pick_point();
        w.query_point = pick_point();
        w.query_slot  = pab_pkg::QSLOT_W'($urandom_range(15));
        return w;
    endfunction

    function automatic edge_word_t add_word(logic [pab_pkg::EDGE_W-1:0] id, logic ap,
                                           logic [pab_pkg::PIDX_W-1:0] a, logic bp,
                                           logic [pab_pkg::PIDX_W-1:0] b);
        edge_word_t w;
        w = '0;
        w.operation = pab_pkg::OP_ADD;
        w.edge_id   = id;
        w.a_present = ap;
        w.end_a     = a;
        w.b_present = bp;
        w.end_b     = b;
        return w;
    endfunction

    function automatic edge_word_t query_word(logic [pab_pkg::PIDX_W-1:0] p,
                                             logic [pab_pkg::QSLOT_W-1:0] slot);
        edge_word_t w;
        w = '0;
        w.operation   = pab_pkg::OP_QUERY;
        w.query_point = p;
        w.query_slot  = slot;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------
    task automatic flag_mismatch(string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offers words from the backlog, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        edge_word_t nxt;
        edge_word_t taken;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                taken = '{s_operation, s_edge_id, s_end_a_present, s_end_a,
                          s_end_b_present, s_end_b, s_query_point, s_query_slot};
                owed_results.push_back(build_adjacency(taken));
                words_taken++;
            end
            // a pending word is held unchanged until the block takes it
            if (!s_valid || s_ready) begin
                if (word_backlog.size() > 0 && (steady_run || $urandom_range(99) >= 11)) begin
                    nxt = word_backlog.pop_front();
                    s_valid         <= 1'b1;
                    s_operation     <= nxt.operation;
                    s_edge_id       <= nxt.edge_id;
                    s_end_a_present <= nxt.a_present;
                    s_end_a         <= nxt.end_a;
                    s_end_b_present <= nxt.b_present;
                    s_end_b         <= nxt.end_b;
                    s_query_point   <= nxt.query_point;
                    s_query_slot    <= nxt.query_slot;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each reply word against the oldest prediction,
    // and drives m_ready including one long hold-off
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        reply_t got;
        reply_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_status, m_point_degree, m_entry_valid, m_entry};
                if (owed_results.size() == 0) begin
                    flag_mismatch($sformatf("reply %0d arrived with nothing expected",
                                            results_seen));
                end else begin
                    want = owed_results.pop_front();
                    if (got.status !== want.status)
                        flag_mismatch($sformatf("reply %0d status %0d, expected %0d",
                                                results_seen, got.status, want.status));
                    if (got.degree !== want.degree)
                        flag_mismatch($sformatf("reply %0d degree %0d, expected %0d",
                                                results_seen, got.degree, want.degree));
                    if (got.entry_valid !== want.entry_valid)
                        flag_mismatch($sformatf("reply %0d entry_valid %0b, expected %0b",
                                                results_seen, got.entry_valid,
                                                want.entry_valid));
                    if (got.entry !== want.entry)
                        flag_mismatch($sformatf("reply %0d entry 0x%04h, expected 0x%04h",
                                                results_seen, got.entry, want.entry));
                    if (want.status == pab_pkg::ST_OVERFLOW) overflows_seen++;
                    if (want.status == pab_pkg::ST_IGNORED)  ignored_seen++;
                    if (want.entry_valid)                    hits_seen++;
                end
                results_seen++;
                // back-pressure long enough for the block to fill and stall its input
                if (results_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady_run || ($urandom_range(99) >= 11);
            end
        end
    end

    // Tally of what the driver handed over, for the closing summary
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            if (s_operation == pab_pkg::OP_ADD)   adds_seen++;
            if (s_operation == pab_pkg::OP_QUERY) queries_seen++;
            if (s_operation == pab_pkg::OP_CLEAR) clears_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no handshake on either side for too long ends the run
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("[%0t] no word moved for %0d cycles, %0d replies outstanding",
                     $realtime, STALL_LIMIT, owed_results.size());
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing: reset, directed words, then random phases per setting
    // ------------------------------------------------------------------

    // Wait until every word has gone in and every reply has come back
    task automatic drain();
        do @(negedge aclk);
        while (word_backlog.size() != 0 || s_valid || owed_results.size() != 0);
    endtask

    // Register write; the block is idle whenever this is called
    task automatic write_reg(pab_pkg::reg_idx_t idx, logic [pab_pkg::CFG_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            pab_pkg::REG_MODE:       mode_cfg       = value[0];
            pab_pkg::REG_FIRST_EDGE: first_edge_cfg = value;
            pab_pkg::REG_LAST_EDGE:  last_edge_cfg  = value;
            default: ;
        endcase
    endtask

    task automatic random_phase(bit m, logic [pab_pkg::CFG_W-1:0] first,
                                logic [pab_pkg::CFG_W-1:0] last, int count, bit calm);
        drain();
        write_reg(pab_pkg::REG_MODE, pab_pkg::CFG_W'(m));
        write_reg(pab_pkg::REG_FIRST_EDGE, first);
        write_reg(pab_pkg::REG_LAST_EDGE, last);
        @(negedge aclk);
        steady_run = calm;
        repeat (count) word_backlog.push_back(random_word());
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, reset settings: edge ids recorded, full id range
        word_backlog.push_back(query_word(12'd0, 4'd15));               // empty after reset
        word_backlog.push_back(add_word(16'd0, 1'b1, 12'd0, 1'b1, 12'd4095)); // extremes
        word_backlog.push_back(add_word(16'hFFFF, 1'b1, 12'd4095, 1'b0, 12'd0));
        word_backlog.push_back(add_word(16'd1234, 1'b0, 12'd7, 1'b1, 12'd0)); // second only
        word_backlog.push_back(add_word(16'd77, 1'b0, 12'd0, 1'b0, 12'd0)); // nothing
        word_backlog.push_back('1);                                     // unused code, all ones
        // self-loop adds two per word: eight fill the list, the ninth overflows
        for (int i = 0; i < 9; i++)
            word_backlog.push_back(add_word(pab_pkg::EDGE_W'(300 + i), 1'b1, 12'd5,
                                            1'b1, 12'd5));
        word_backlog.push_back(query_word(12'd5, 4'd15));
        word_backlog.push_back(query_word(12'd4095, 4'd1));
        word_backlog.push_back(query_word(12'd0, 4'd0));
        word_backlog.push_back('{pab_pkg::OP_CLEAR, 16'h0, 1'b0, 12'h0, 1'b0, 12'h0,
                                 12'h0, 4'h0});
        word_backlog.push_back(query_word(12'd5, 4'd0));                // degree gone after clear
        drain();

        // directed, neighbour mode over a narrow id range
        write_reg(pab_pkg::REG_MODE, pab_pkg::CFG_W'(MODE_NEIGHBOURS));
        write_reg(pab_pkg::REG_FIRST_EDGE, 16'd10);
        write_reg(pab_pkg::REG_LAST_EDGE, 16'd20);
        @(negedge aclk);
        word_backlog.push_back(add_word(16'd9, 1'b1, 12'd1, 1'b1, 12'd2));    // below range
        word_backlog.push_back(add_word(16'd21, 1'b1, 12'd1, 1'b1, 12'd2));   // above range
        word_backlog.push_back(add_word(16'd10, 1'b1, 12'd1, 1'b0, 12'd2));   // one end missing
        word_backlog.push_back(add_word(16'd20, 1'b1, 12'd100, 1'b1, 12'd200));
        word_backlog.push_back(add_word(16'd15, 1'b1, 12'd9, 1'b1, 12'd9));   // self-loop
        word_backlog.push_back(query_word(12'd200, 4'd0));

        // random phases: full range, no-idle stretch, middle range,
        // empty range, single id, single id at the top
        random_phase(MODE_EDGE_IDS,   16'h0000, 16'hFFFF, 250, 1'b0);
        random_phase(MODE_NEIGHBOURS, 16'h0000, 16'hFFFF, 250, 1'b1);
        random_phase(MODE_EDGE_IDS,   16'd1000, 16'd50000, 200, 1'b0);
        random_phase(MODE_NEIGHBOURS, 16'hFFFF, 16'h0000, 60, 1'b0);
        random_phase(MODE_NEIGHBOURS, 16'd300,  16'd300,  150, 1'b0);
        random_phase(MODE_EDGE_IDS,   16'hFFFF, 16'hFFFF, 90, 1'b0);
        drain();

        // a few more cycles in case a stray reply follows
        repeat (8) @(posedge aclk);
        if (owed_results.size() != 0)
            flag_mismatch($sformatf("%0d replies never arrived", owed_results.size()));

        $display("run covered %0d words: %0d adds (%0d overflowed, %0d ignored),",
                 words_taken, adds_seen, overflows_seen, ignored_seen);
        $display("  %0d queries (%0d read an entry), %0d clears, %0d mismatches",
                 queries_seen, hits_seen, clears_seen, mismatches);
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// File: point_adjacency_builder_unit.f
design/pab_pkg.sv
design/pab_store.sv
design/point_adjacency_builder_unit.sv
dv/testbench.sv
